// ----- src/serial_reference_frame_decoder_assert.svh -----
// ----------------------------------------------------------------------------
// serial reference frame decoder assertion macros
// clocked property wrappers shared by the decoder modules
// ----------------------------------------------------------------------------
`ifndef SERIAL_REFERENCE_FRAME_DECODER_ASSERT_SVH
`define SERIAL_REFERENCE_FRAME_DECODER_ASSERT_SVH

// same-cycle implication, checked outside reset
`define SRFD_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define SRFD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- src/srfd_pkg.sv -----
// ----------------------------------------------------------------------------
// srfd_pkg
// types and constants shared by the serial reference frame decoder
// ----------------------------------------------------------------------------
package srfd_pkg;

    localparam logic [7:0] HDR0    = 8'hFF;
    localparam logic [7:0] HDR1    = 8'h88;
    localparam logic [7:0] HDR2    = 8'h77;
    localparam logic [7:0] TRAILER = 8'h11;

    // frame byte count: header takes 0..2, payload 3..5, trailer at 6
    localparam logic [2:0] CNT_FIRST_PAYLOAD = 3'd3;
    localparam logic [2:0] CNT_TRAILER       = 3'd6;

    // offset that turns a floor division by 65535 into a ceiling division
    localparam logic signed [32:0] CEIL_ADJ = 33'sd65534;

    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_REF_MIN = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_REF_MAX = 4'd1;

    localparam logic signed [15:0] REF_MIN_RESET = 16'sd0;
    localparam logic signed [15:0] REF_MAX_RESET = 16'sd32767;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_HDR1,
        PH_HDR2,
        PH_BODY
    } phase_t;

    typedef struct packed {
        logic [15:0] ref_raw;
        logic [7:0]  aux_byte;
    } frame_t;

endpackage

// ----- src/srfd_parser.sv -----
// ----------------------------------------------------------------------------
// srfd_parser
// byte-level frame parser: header match, payload capture, trailer check
// ----------------------------------------------------------------------------
`include "serial_reference_frame_decoder_assert.svh"

module srfd_parser
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            byte_valid,
    input  logic [7:0]      byte_data,
    input  logic            byte_ready,
    output logic            frame_valid,
    output srfd_pkg::frame_t frame
);
    import srfd_pkg::*;

    phase_t     phase_reg;
    phase_t     phase_next;
    logic [2:0] cnt_reg;
    logic [2:0] cnt_next;
    logic [7:0] store_reg [3];
    logic       store_we;
    logic [2:0] store_off;
    logic [1:0] store_idx;
    logic       byte_acc;
    logic       emit;

    assign byte_acc  = byte_valid && byte_ready;
    assign store_off = cnt_reg - CNT_FIRST_PAYLOAD;
    assign store_idx = store_off[1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            cnt_reg   <= 3'd0;
        end
        else
        begin
            phase_reg <= phase_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_comb
    begin
        phase_next = phase_reg;
        cnt_next   = cnt_reg;
        store_we   = 1'b0;
        emit       = 1'b0;
        if (byte_acc)
        begin
            case (phase_reg)
                PH_IDLE:
                begin
                    if (byte_data == HDR0)
                    begin
                        phase_next = PH_HDR1;
                        cnt_next   = 3'd1;
                    end
                end
                PH_HDR1:
                begin
                    // a bad header byte is dropped, not taken as a fresh start
                    if (byte_data == HDR1)
                    begin
                        phase_next = PH_HDR2;
                        cnt_next   = 3'd2;
                    end
                    else
                    begin
                        phase_next = PH_IDLE;
                        cnt_next   = 3'd0;
                    end
                end
                PH_HDR2:
                begin
                    if (byte_data == HDR2)
                    begin
                        phase_next = PH_BODY;
                        cnt_next   = CNT_FIRST_PAYLOAD;
                    end
                    else
                    begin
                        phase_next = PH_IDLE;
                        cnt_next   = 3'd0;
                    end
                end
                PH_BODY:
                begin
                    if (cnt_reg >= CNT_FIRST_PAYLOAD && cnt_reg < CNT_TRAILER)
                    begin
                        store_we = 1'b1;
                        cnt_next = cnt_reg + 3'd1;
                    end
                    else
                    begin
                        // bad trailer drops the frame quietly
                        emit       = (cnt_reg == CNT_TRAILER) && (byte_data == TRAILER);
                        phase_next = PH_IDLE;
                        cnt_next   = 3'd0;
                    end
                end
                default:
                begin
                    phase_next = PH_IDLE;
                    cnt_next   = 3'd0;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (store_we)
        begin
            store_reg[store_idx] <= byte_data;
        end
    end

    assign frame_valid    = emit;
    assign frame.ref_raw  = {store_reg[1], store_reg[0]};
    assign frame.aux_byte = store_reg[2];

    `SRFD_ASSERT_NOW(a_idle_count, clk, rst_n, phase_reg == PH_IDLE, cnt_reg == 3'd0,
        "idle parser holds a nonzero byte count")
    `SRFD_ASSERT_NOW(a_body_count, clk, rst_n, phase_reg == PH_BODY,
        cnt_reg >= CNT_FIRST_PAYLOAD && cnt_reg <= CNT_TRAILER,
        "payload phase count out of frame range")
    `SRFD_ASSERT_NEXT(a_emit_idle, clk, rst_n, emit, phase_reg == PH_IDLE,
        "parser did not return to idle after a frame")

endmodule

// ----- src/srfd_scale.sv -----
// ----------------------------------------------------------------------------
// srfd_scale
// pipelined linear scaling of the raw code into signed q16.16
// ----------------------------------------------------------------------------
`include "serial_reference_frame_decoder_assert.svh"

module srfd_scale
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic signed [15:0]      ref_min,
    input  logic signed [15:0]      ref_max,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  srfd_pkg::frame_t        in_frame,
    output logic                    out_valid,
    input  logic                    out_ready,
    output srfd_pkg::frame_t        out_frame,
    output logic signed [31:0]      out_scaled
);
    import srfd_pkg::*;

    // stage 1: frame capture
    logic              s1_valid_reg;
    frame_t            s1_frame_reg;
    // stage 2: product raw * span
    logic              s2_valid_reg;
    frame_t            s2_frame_reg;
    logic signed [32:0] s2_p_reg;
    // stage 3: dividend for the floor division by 65535
    logic              s3_valid_reg;
    frame_t            s3_frame_reg;
    logic signed [32:0] s3_p_reg;
    logic [31:0]       s3_n_reg;
    logic              s3_neg_reg;
    // stage 4: quotient magnitude
    logic              s4_valid_reg;
    frame_t            s4_frame_reg;
    logic signed [32:0] s4_p_reg;
    logic [15:0]       s4_q_reg;
    logic              s4_neg_reg;
    // stage 5: result register
    logic              s5_valid_reg;
    frame_t            s5_frame_reg;
    logic signed [31:0] s5_scaled_reg;

    logic              rdy1;
    logic              rdy2;
    logic              rdy3;
    logic              rdy4;
    logic              rdy5;

    logic signed [16:0] span;
    logic signed [33:0] prod;
    logic signed [32:0] s2_p_next;
    logic signed [32:0] adj;
    logic [31:0]       s3_n_next;
    logic [31:0]       qsum;
    logic [15:0]       s4_q_next;
    logic signed [16:0] fq;
    logic [33:0]       total;
    logic signed [31:0] s5_scaled_next;
    logic signed [31:0] lim_lo;
    logic signed [31:0] lim_hi;

    assign rdy5 = !s5_valid_reg || out_ready;
    assign rdy4 = !s4_valid_reg || rdy5;
    assign rdy3 = !s3_valid_reg || rdy4;
    assign rdy2 = !s2_valid_reg || rdy3;
    assign rdy1 = !s1_valid_reg || rdy2;
    assign in_ready = rdy1;

    assign span      = {ref_max[15], ref_max} - {ref_min[15], ref_min};
    assign prod      = $signed({1'b0, s1_frame_reg.ref_raw}) * span;
    assign s2_p_next = prod[32:0];

    // floor(p / 65535) for negative p is -ceil(|p| / 65535)
    assign adj       = CEIL_ADJ - s2_p_reg;
    assign s3_n_next = s2_p_reg[32] ? adj[31:0] : s2_p_reg[31:0];

    // exact n / 65535 for n below 65535 * 65536
    assign qsum      = s3_n_reg + {16'h0000, s3_n_reg[31:16]} + 32'd1;
    assign s4_q_next = qsum[31:16];

    assign fq    = s4_neg_reg ? -$signed({1'b0, s4_q_reg}) : $signed({1'b0, s4_q_reg});
    assign total = {{2{ref_min[15]}}, ref_min, 16'h0000}
                 + {s4_p_reg[32], s4_p_reg}
                 + {{17{fq[16]}}, fq};
    assign s5_scaled_next = total[31:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
            s5_valid_reg <= 1'b0;
        end
        else
        begin
            if (rdy1) s1_valid_reg <= in_valid;
            if (rdy2) s2_valid_reg <= s1_valid_reg;
            if (rdy3) s3_valid_reg <= s2_valid_reg;
            if (rdy4) s4_valid_reg <= s3_valid_reg;
            if (rdy5) s5_valid_reg <= s4_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy1 && in_valid)
        begin
            s1_frame_reg <= in_frame;
        end
        if (rdy2 && s1_valid_reg)
        begin
            s2_frame_reg <= s1_frame_reg;
            s2_p_reg     <= s2_p_next;
        end
        if (rdy3 && s2_valid_reg)
        begin
            s3_frame_reg <= s2_frame_reg;
            s3_p_reg     <= s2_p_reg;
            s3_n_reg     <= s3_n_next;
            s3_neg_reg   <= s2_p_reg[32];
        end
        if (rdy4 && s3_valid_reg)
        begin
            s4_frame_reg <= s3_frame_reg;
            s4_p_reg     <= s3_p_reg;
            s4_q_reg     <= s4_q_next;
            s4_neg_reg   <= s3_neg_reg;
        end
        if (rdy5 && s4_valid_reg)
        begin
            s5_frame_reg  <= s4_frame_reg;
            s5_scaled_reg <= s5_scaled_next;
        end
    end

    assign out_valid  = s5_valid_reg;
    assign out_frame  = s5_frame_reg;
    assign out_scaled = s5_scaled_reg;

    assign lim_lo = (ref_min < ref_max) ? {ref_min, 16'h0000} : {ref_max, 16'h0000};
    assign lim_hi = (ref_min < ref_max) ? {ref_max, 16'h0000} : {ref_min, 16'h0000};

    `SRFD_ASSERT_NOW(a_full_when_stalled, clk, rst_n, !in_ready,
        s1_valid_reg && s2_valid_reg && s3_valid_reg && s4_valid_reg && s5_valid_reg,
        "input held back while the pipeline has a free slot")
    `SRFD_ASSERT_NOW(a_scaled_range, clk, rst_n, s5_valid_reg,
        s5_scaled_reg >= lim_lo && s5_scaled_reg <= lim_hi,
        "scaled reference outside the configured range")

endmodule

// ----- src/serial_reference_frame_decoder.sv -----
// ----------------------------------------------------------------------------
// serial_reference_frame_decoder
// finds ff 88 77 p0 p1 p2 11 frames in a byte stream and scales the reference
// ----------------------------------------------------------------------------
// Takes one received byte per clock on the slave stream. A frame with a good
// trailer yields one result on the master stream holding the raw 16-bit code
// ({p1, p0}), the third payload byte and ref_min + raw*(ref_max-ref_min)/65535
// as signed q16.16, rounded toward minus infinity. The result passes
// through a five-stage scaling pipeline (capture, multiply, dividend
// fix-up, quotient, final sum). The input side takes a byte every cycle
// and only stalls when all five stages hold frames that the master side
// has not yet taken. ref_min and ref_max are written through the cfg port,
// which is always ready; write them only while no frame is in flight.
module serial_reference_frame_decoder
(
    input  logic                              clk,
    input  logic                              rst_n,
    // configuration writes
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [srfd_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [srfd_pkg::CFG_DATA_W-1:0]   cfg_data,
    // received bytes
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [7:0]                        s_tdata,   // [7:0] rx_byte
    // decoded frames
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [55:0]                       m_tdata    // [15:0] ref_raw,
                                                         // [23:16] aux_byte,
                                                         // [55:24] ref_scaled
);
    import srfd_pkg::*;

    logic signed [15:0] ref_min_reg;
    logic signed [15:0] ref_max_reg;
    logic               frame_valid;
    frame_t             frame;
    frame_t             out_frame;
    logic signed [31:0] out_scaled;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ref_min_reg <= REF_MIN_RESET;
            ref_max_reg <= REF_MAX_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_REF_MIN: ref_min_reg <= $signed(cfg_data);
                CFG_REF_MAX: ref_max_reg <= $signed(cfg_data);
                default:     ;
            endcase
        end
    end

    srfd_parser u_parser
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .byte_valid  (s_tvalid),
        .byte_data   (s_tdata),
        .byte_ready  (s_tready),
        .frame_valid (frame_valid),
        .frame       (frame)
    );

    srfd_scale u_scale
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .ref_min    (ref_min_reg),
        .ref_max    (ref_max_reg),
        .in_valid   (frame_valid),
        .in_ready   (s_tready),
        .in_frame   (frame),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_frame  (out_frame),
        .out_scaled (out_scaled)
    );

    assign m_tdata = {out_scaled, out_frame.aux_byte, out_frame.ref_raw};

endmodule

// ----- tb/serial_reference_frame_decoder_tb.sv -----
// ----------------------------------------------------------------------------
// serial_reference_frame_decoder_tb
// self-checking bench for the serial reference frame decoder
// ----------------------------------------------------------------------------
// Feeds byte streams of good, broken and noisy frames through the slave
// stream under several ref_min/ref_max settings. A frame tracker in the bench
// follows the parser state and the scaling arithmetic and queues the result
// each good frame should give. Every result taken from the master stream is
// checked field by field against the oldest queued one. Both stream sides
// idle at random, and the receiver also holds off for one long stretch.
// ----------------------------------------------------------------------------
module serial_reference_frame_decoder_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import srfd_pkg::*;

    localparam int     HOLD_CYCLES   = 200;
    localparam int     SETTLE_CYCLES = 10;
    localparam longint CODE_SPAN     = 65535;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 4'd9;

    typedef struct {
        logic [15:0] raw;
        logic [7:0]  aux;
        logic [31:0] scaled;
    } frame_result_t;

    logic                   clk;
    logic                   rst_n;
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [CFG_IDX_W-1:0]   cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [7:0]             s_tdata;
    logic                   m_tvalid;
    logic                   m_tready;
    logic [55:0]            m_tdata;

    // bench copy of the block state and registers
    phase_t                 rx_phase;
    logic [2:0]             rx_count;
    logic [7:0]             payload [3];
    logic signed [15:0]     ref_min_q;
    logic signed [15:0]     ref_max_q;

    frame_result_t          pending_frames [$];
    int unsigned            n_errors;
    int unsigned            n_sent;
    bit                     sender_gaps;
    bit                     sink_gaps;
    bit                     hold_req;

    serial_reference_frame_decoder uut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // floor(raw * span * 65536 / 65535) on top of ref_min, in q16.16
    function automatic logic [31:0] scaled_ref(input logic [15:0] raw);
        longint span;
        longint num;
        longint quot;
        span = longint'(ref_max_q) - longint'(ref_min_q);
        num  = longint'(raw) * span * 65536;
        quot = num / CODE_SPAN;
        if (num % CODE_SPAN != 0 && num < 0)
            quot = quot - 1;
        return 32'(longint'(ref_min_q) * 65536 + quot);
    endfunction

    task automatic track_rx_byte(input logic [7:0] b);
        frame_result_t r;
        case (rx_phase)
            PH_IDLE:
                if (b == HDR0)
                begin
                    rx_phase = PH_HDR1;
                    rx_count = 3'd1;
                end
            PH_HDR1:
                if (b == HDR1)
                begin
                    rx_phase = PH_HDR2;
                    rx_count = 3'd2;
                end
                else
                begin
                    rx_phase = PH_IDLE;
                    rx_count = '0;
                end
            PH_HDR2:
                if (b == HDR2)
                begin
                    rx_phase = PH_BODY;
                    rx_count = CNT_FIRST_PAYLOAD;
                end
                else
                begin
                    rx_phase = PH_IDLE;
                    rx_count = '0;
                end
            default:
                if (rx_count >= CNT_FIRST_PAYLOAD && rx_count < CNT_TRAILER)
                begin
                    payload[rx_count - CNT_FIRST_PAYLOAD] = b;
                    rx_count = rx_count + 3'd1;
                end
                else
                begin
                    if (rx_count == CNT_TRAILER && b == TRAILER)
                    begin
                        r.raw    = {payload[1], payload[0]};
                        r.aux    = payload[2];
                        r.scaled = scaled_ref(r.raw);
                        pending_frames.push_back(r);
                    end
                    rx_phase = PH_IDLE;
                    rx_count = '0;
                end
        endcase
    endtask

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("%0t mismatch on %s: got %h, expected %h", $realtime, what, got, want);
        n_errors++;
    endtask

    // result checker
    always @(posedge clk)
    begin
        frame_result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_frames.size() == 0)
            begin
                report_mismatch("unexpected frame", m_tdata[31:0], '0);
            end
            else
            begin
                want = pending_frames.pop_front();
                if (m_tdata[15:0] !== want.raw)
                    report_mismatch("ref_raw", 32'(m_tdata[15:0]), 32'(want.raw));
                if (m_tdata[23:16] !== want.aux)
                    report_mismatch("aux_byte", 32'(m_tdata[23:16]), 32'(want.aux));
                if (m_tdata[55:24] !== want.scaled)
                    report_mismatch("ref_scaled", m_tdata[55:24], want.scaled);
            end
        end
    end

    // receiver side: random stalls, one long hold-off on request
    initial
    begin : sink_ready
        int n;
        m_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                hold_req = 1'b0;
                m_tready <= 1'b0;
                for (n = 1; n < HOLD_CYCLES; n++)
                    @(negedge clk);
            end
            else if (sink_gaps && $urandom_range(0, 5) == 0)
            begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 10) - 1) @(negedge clk);
            end
            else
            begin
                m_tready <= 1'b1;
            end
        end
    end

    task automatic send_byte(input logic [7:0] b);
        @(negedge clk);
        if (sender_gaps && $urandom_range(0, 4) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        track_rx_byte(b);
        n_sent++;
    endtask

    task automatic send_frame(input logic [7:0] p0, input logic [7:0] p1,
                              input logic [7:0] p2, input logic [7:0] tr);
        send_byte(HDR0);
        send_byte(HDR1);
        send_byte(HDR2);
        send_byte(p0);
        send_byte(p1);
        send_byte(p2);
        send_byte(tr);
    endtask

    // stop offering and wait for every queued frame, then let the pipe settle
    task automatic wait_results();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (pending_frames.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        if (idx == CFG_REF_MIN)
            ref_min_q = val;
        else if (idx == CFG_REF_MAX)
            ref_max_q = val;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [7:0] rand_payload();
        case ($urandom_range(0, 7))
            0:       return 8'h00;
            1:       return 8'hFF;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic logic [7:0] wrong_byte(input logic [7:0] good);
        logic [7:0] b;
        if (good != HDR0 && $urandom_range(0, 2) == 0)
            return HDR0;
        do
            b = 8'($urandom_range(0, 255));
        while (b == good);
        return b;
    endfunction

    // mostly good frames, some idle noise and frames broken in the header or trailer
    task automatic random_frames(input int unsigned n_items);
        int unsigned done;
        int unsigned sel;
        int unsigned cut;
        int unsigned i;
        logic [7:0]  fb [7];
        done = 0;
        while (done < n_items)
        begin
            sel = $urandom_range(0, 9);
            if (sel < 7)
            begin
                send_frame(rand_payload(), rand_payload(), rand_payload(), TRAILER);
                done += 7;
            end
            else if (sel == 7)
            begin
                send_byte(8'($urandom_range(0, 254)));
            end
            else
            begin
                fb[0] = HDR0;
                fb[1] = HDR1;
                fb[2] = HDR2;
                fb[3] = rand_payload();
                fb[4] = rand_payload();
                fb[5] = rand_payload();
                fb[6] = TRAILER;
                sel = $urandom_range(0, 2);
                cut = (sel == 2) ? 6 : sel + 1;
                for (i = 0; i < cut; i++)
                    send_byte(fb[i]);
                send_byte(wrong_byte(fb[cut]));
                done += cut + 1;
            end
        end
    endtask

    task automatic run_setting(input logic [15:0] lo, input logic [15:0] hi,
                               input int unsigned n_items);
        wait_results();
        write_reg(CFG_REF_MIN, lo);
        write_reg(CFG_REF_MAX, hi);
        write_reg(CFG_UNUSED, 16'($urandom));
        random_frames(n_items);
    endtask

    // reset register values, field extremes and every parser special case
    task automatic test_directed();
        send_frame(8'h00, 8'h00, 8'h00, TRAILER);
        // idle byte ignored, then a second 0xff is a bad header and is not a new start
        send_byte(8'h42);
        send_byte(HDR0);
        send_byte(HDR0);
        send_byte(HDR1);
        // bad third header byte
        send_byte(HDR0);
        send_byte(HDR1);
        send_byte(HDR0);
        // bad trailer drops the frame
        send_frame(8'hFF, 8'hFF, 8'hFF, 8'h22);
        send_frame(8'hFF, 8'hFF, 8'hFF, TRAILER);
    endtask

    // full range, reversed range, empty span and both rails
    task automatic test_scale_settings();
        run_setting(16'h8000, 16'h7FFF, 70);
        run_setting(16'h7FFF, 16'h8000, 70);
        run_setting(16'h0000, 16'h0000, 50);
        run_setting(16'h8000, 16'h8000, 40);
        run_setting(16'h7FFF, 16'h7FFF, 40);
        run_setting(16'h0064, 16'hFFFB, 60);
        run_setting(16'($urandom), 16'($urandom), 60);
        run_setting(16'($urandom), 16'($urandom), 60);
    endtask

    // receiver holds off long enough that the pipe fills and the input stalls
    task automatic test_backpressure();
        int unsigned i;
        sender_gaps = 1'b0;
        hold_req    = 1'b1;
        for (i = 0; i < 10; i++)
            send_frame(rand_payload(), rand_payload(), rand_payload(), TRAILER);
        sender_gaps = 1'b1;
    endtask

    // sender pauses until every request in flight has come back
    task automatic test_drain_pause();
        random_frames(30);
        wait_results();
        random_frames(30);
    endtask

    task automatic test_no_idle();
        sender_gaps = 1'b0;
        sink_gaps   = 1'b0;
        random_frames(70);
    endtask

    initial
    begin
        rst_n       = 1'b0;
        cfg_valid   = 1'b0;
        cfg_index   = '0;
        cfg_data    = '0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        rx_phase    = PH_IDLE;
        rx_count    = '0;
        payload[0]  = '0;
        payload[1]  = '0;
        payload[2]  = '0;
        ref_min_q   = REF_MIN_RESET;
        ref_max_q   = REF_MAX_RESET;
        n_errors    = 0;
        n_sent      = 0;
        sender_gaps = 1'b1;
        sink_gaps   = 1'b1;
        hold_req    = 1'b0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_directed();
        test_scale_settings();
        test_backpressure();
        test_drain_pause();
        test_no_idle();

        wait_results();
        if (n_errors == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

    initial
    begin
        #(5_000_000);
        $display("FAILED: results differ");
        $finish;
    end

endmodule

// ----- serial_reference_frame_decoder.f -----
+incdir+src
src/srfd_pkg.sv
src/srfd_parser.sv
src/srfd_scale.sv
src/serial_reference_frame_decoder.sv
tb/serial_reference_frame_decoder_tb.sv
